### rtl/sps_pkg.sv
`timescale 1ns / 1ps
package sps_pkg;
    localparam int SEG_WIDTH_DEF = 64;
    localparam int DEPTH_DEF     = 131072;
    localparam int OPC_W   = 1;
    localparam int IDX_W   = 17;
    localparam int VAL_W   = 21;
    localparam int LOW_W   = 48;
    localparam int CNT_W   = 18;
    localparam int MASK_W  = 64;
    localparam int IN_W    = 88;   // 17 + 21 + 48 = 86, padded to bytes
    localparam int OUT_W   = 112;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SIEVE = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] table_index;
        logic [VAL_W-1:0] prime_value;
        logic [LOW_W-1:0] segment_low;
    } t_cmd;
endpackage

### rtl/sps_front.sv
`timescale 1ns / 1ps
// Accept items into a two-entry queue.
module sps_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  sps_pkg::t_cmd i_cmd,
    output logic         o_valid,
    input  logic         i_ready,
    output sps_pkg::t_cmd o_cmd
);
    import sps_pkg::*;
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### rtl/sps_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: remainder = a mod b.
module sps_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sps_pkg::LOW_W:0]   i_a,
    input  logic [sps_pkg::VAL_W-1:0] i_b,
    output logic                      o_done,
    output logic [sps_pkg::VAL_W-1:0] o_rem
);
    import sps_pkg::*;
    logic [LOW_W:0]   r_q;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_b;
    logic [5:0]       r_n;
    logic             r_busy;
    logic [VAL_W:0]   trial;
    logic [VAL_W:0]   diff;

    assign trial  = {r_rem, r_q[LOW_W]};
    assign diff   = trial - {1'b0, r_b};
    assign o_rem  = r_rem;
    assign o_done = r_busy && (r_n == 6'd0);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_a;
            r_rem <= '0;
            r_b   <= i_b;
            r_n   <= 6'(LOW_W + 1);
        end else if (r_busy && r_n != 6'd0) begin
            r_n <= r_n - 6'd1;
            if (!diff[VAL_W]) begin
                r_rem <= diff[VAL_W-1:0];
                r_q   <= {r_q[LOW_W-1:0], 1'b1};
            end else begin
                r_rem <= trial[VAL_W-1:0];
                r_q   <= {r_q[LOW_W-1:0], 1'b0};
            end
        end
        if (!i_rst_n) r_busy <= 1'b0;
        else if (i_start) r_busy <= 1'b1;
        else if (o_done) r_busy <= 1'b0;
    end
endmodule

### rtl/sps_back.sv
`timescale 1ns / 1ps
// Table memory and the sieve sequencer.
module sps_back #(
    parameter int SEGMENT_WIDTH    = sps_pkg::SEG_WIDTH_DEF,
    parameter int BASE_PRIME_DEPTH = sps_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  sps_pkg::t_cmd              i_cmd,
    input  logic [sps_pkg::CNT_W-1:0]  i_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sps_pkg::MASK_W-1:0] o_mask,
    output logic [sps_pkg::LOW_W-1:0]  o_base
);
    import sps_pkg::*;
    localparam int AW  = $clog2(BASE_PRIME_DEPTH);
    localparam int PW  = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam int LIM = (SEGMENT_WIDTH < 64) ? SEGMENT_WIDTH : 64;
    localparam logic [MASK_W-1:0] RMASK =
        (SEGMENT_WIDTH >= 64) ? '1 : ((MASK_W'(1) << LIM) - MASK_W'(1));

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_RD   = 7'b0000010, S_WAIT = 7'b0000100,
        S_CHK  = 7'b0001000, S_DIV  = 7'b0010000, S_MUL  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    logic [VAL_W-1:0] r_mem [BASE_PRIME_DEPTH];
    logic [VAL_W-1:0] r_rd;
    t_state r_st;
    logic [PW-1:0] r_i, r_cnt;
    logic [LOW_W-1:0] r_low;
    logic [LOW_W:0]   r_top;
    logic [MASK_W-1:0] r_mask;
    logic [MASK_W-1:0] r_omask;
    logic [LOW_W-1:0]  r_obase;
    logic [VAL_W-1:0] r_p;
    logic [2*VAL_W-1:0] r_sq;
    logic [LOW_W+VAL_W:0] r_m;
    logic r_vld;
    logic div_go, div_done;
    logic [VAL_W-1:0] div_rem;
    logic [LOW_W:0] num;
    logic [PW-1:0] cnt_sat;
    logic [LOW_W+VAL_W:0] off;

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_vld;
    assign o_base  = r_obase;
    assign o_mask  = r_omask;
    assign num     = {1'b0, r_low} + (LOW_W+1)'(r_p) - (LOW_W+1)'(1);
    assign div_go  = (r_st == S_CHK) && (r_p >= VAL_W'(2))
                     && ((LOW_W+1)'(r_sq) <= r_top);
    assign off     = r_m - (LOW_W+VAL_W+1)'(r_low);
    assign cnt_sat = ({{(PW-CNT_W){1'b0}}, i_count} > PW'(BASE_PRIME_DEPTH))
                     ? PW'(BASE_PRIME_DEPTH) : PW'(i_count);

    sps_div u_div (
        .i_clk, .i_rst_n, .i_start(div_go), .i_a(num), .i_b(r_p),
        .o_done(div_done), .o_rem(div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_cmd.opcode == OP_LOAD
            && {1'b0, i_cmd.table_index} < (IDX_W+1)'(BASE_PRIME_DEPTH))
            r_mem[i_cmd.table_index[AW-1:0]] <= i_cmd.prime_value;
        r_rd <= r_mem[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_vld <= 1'b0;
        end else begin
            if (r_vld && i_ready) r_vld <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid && o_ready && i_cmd.opcode == OP_SIEVE) begin
                    r_low  <= i_cmd.segment_low;
                    r_top  <= {1'b0, i_cmd.segment_low} + (LOW_W+1)'(SEGMENT_WIDTH - 1);
                    r_mask <= RMASK;
                    r_i    <= '0;
                    r_cnt  <= cnt_sat;
                    r_st   <= S_RD;
                end
                S_RD: r_st <= (r_i >= r_cnt) ? S_OUT : S_WAIT;
                S_WAIT: begin
                    r_p  <= r_rd;
                    r_sq <= r_rd * r_rd;
                    r_st <= S_CHK;
                end
                S_CHK: begin
                    if (r_p < VAL_W'(2)) begin
                        r_i <= r_i + PW'(1); r_st <= S_RD;
                    end else if ((LOW_W+1)'(r_sq) > r_top) r_st <= S_OUT;
                    else r_st <= S_DIV;
                end
                // first multiple at or above low: (low + p - 1) minus its remainder
                S_DIV: if (div_done) begin
                    r_m  <= (LOW_W+VAL_W+1)'(num - (LOW_W+1)'(div_rem));
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    if (r_m < (LOW_W+VAL_W+1)'(r_sq)) r_m <= (LOW_W+VAL_W+1)'(r_sq);
                    else if (r_m <= (LOW_W+VAL_W+1)'(r_top) && off < (LOW_W+VAL_W+1)'(LIM)) begin
                        r_mask[off[5:0]] <= 1'b0;
                        r_m <= r_m + (LOW_W+VAL_W+1)'(r_p);
                    end else begin
                        r_i <= r_i + PW'(1); r_st <= S_RD;
                    end
                end
                // hold until the previous result has left
                S_OUT: if (!r_vld) begin
                    if (r_low == '0) r_omask <= r_mask & ~MASK_W'(3) & RMASK;
                    else if (r_low == LOW_W'(1)) r_omask <= r_mask & ~MASK_W'(1) & RMASK;
                    else r_omask <= r_mask & RMASK;
                    r_obase <= r_low;
                    r_vld   <= 1'b1;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/segmented_prime_sieve_unit.sv
`timescale 1ns / 1ps
// Segmented sieve: load items fill the base prime table; a sieve item walks the
// table, reading each entry, finding its first multiple with the bit-serial
// divider and clearing the multiples in turn, for each base prime up to the
// square root of the segment's top. Loads queue behind a running sieve; a
// finished mask waits in its own output register, so the next items are taken
// while it is held. No clearing pass: unwritten entries read as garbage.
module segmented_prime_sieve_unit #(
    parameter int SEGMENT_WIDTH    = sps_pkg::SEG_WIDTH_DEF,
    parameter int BASE_PRIME_DEPTH = sps_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [sps_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [sps_pkg::IN_W-1:0]  s_axis_tdata,  // table_index, prime_value, segment_low
    input  logic                      s_axis_tuser,  // opcode
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [sps_pkg::OUT_W-1:0] m_axis_tdata   // prime_mask, segment_base
);
    import sps_pkg::*;
    logic [CNT_W-1:0] r_count;
    t_cmd in_cmd, q_cmd;
    logic q_valid, q_ready;
    logic [MASK_W-1:0] mask;
    logic [LOW_W-1:0] base;

    assign in_cmd = '{opcode: s_axis_tuser, table_index: s_axis_tdata[16:0],
                      prime_value: s_axis_tdata[37:17], segment_low: s_axis_tdata[85:38]};
    assign m_axis_tdata = {base, mask};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else if (i_cfg_we) r_count <= i_cfg_wdata;
    end

    sps_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(in_cmd), .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    sps_back #(.SEGMENT_WIDTH(SEGMENT_WIDTH), .BASE_PRIME_DEPTH(BASE_PRIME_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .i_count(r_count), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_mask(mask), .o_base(base)
    );

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_low01: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[111:64] == '0 |-> m_axis_tdata[1:0] == 2'b00)
        else $error("0 or 1 marked prime");
`endif
endmodule
